>>> sv/gdb_pkg.sv
// ----------------------------------------------------------------------------
// gdb_pkg
// Shared types and constants for the grayscale desaturation blend pipeline.
// ----------------------------------------------------------------------------
package gdb_pkg;

	localparam int CHAN_W   = 8;
	localparam int AMT_W    = 9;
	localparam int PROD_W   = 24;
	localparam int GRAY_W   = 24;
	localparam int AGRAY_W  = 32;
	localparam int WCHAN_W  = 16;
	localparam int ACC_W    = 33;

	// BT.601 luma weights in Q0.16, summing to 65536
	localparam logic [15:0] LUMA_WR = 16'd19595;
	localparam logic [15:0] LUMA_WG = 16'd38470;
	localparam logic [15:0] LUMA_WB = 16'd7471;

	localparam logic [AMT_W-1:0]  AMOUNT_FULL = 9'd256;
	localparam logic [ACC_W-1:0]  ROUND_HALF  = 33'h000800000;
	localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'hFF;

	// red in the lowest byte
	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		pixel_t            pix;
		logic [GRAY_W-1:0] gray;
	} luma_item_t;

endpackage

>>> sv/gdb_luma.sv
// ----------------------------------------------------------------------------
// gdb_luma
// Two-stage luma front end: weight products, then the Q8.16 luma sum.
// ----------------------------------------------------------------------------
module gdb_luma import gdb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pixel_t     in_pix,
	output logic       out_valid,
	input  logic       out_ready,
	output luma_item_t out_item
);

	logic              valid_s1;
	logic              valid_s2;
	pixel_t            pix_s1;
	logic [PROD_W-1:0] prod_r_s1;
	logic [PROD_W-1:0] prod_g_s1;
	logic [PROD_W-1:0] prod_b_s1;
	luma_item_t        item_s2;
	logic              en_s1;
	logic              en_s2;

	// a stage advances when it is empty or the next one takes its item
	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			pix_s1    <= in_pix;
			prod_r_s1 <= PROD_W'(LUMA_WR * in_pix.red);
			prod_g_s1 <= PROD_W'(LUMA_WG * in_pix.green);
			prod_b_s1 <= PROD_W'(LUMA_WB * in_pix.blue);
		end
		if (en_s2) begin
			item_s2.pix  <= pix_s1;
			item_s2.gray <= prod_r_s1 + prod_g_s1 + prod_b_s1;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

>>> sv/gdb_mix.sv
// ----------------------------------------------------------------------------
// gdb_mix
// Two-stage blend back end: channel and luma weighting, then round and clamp.
// ----------------------------------------------------------------------------
module gdb_mix import gdb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AMT_W-1:0] amount,
	input  logic             in_valid,
	output logic             in_ready,
	input  luma_item_t       in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output pixel_t           out_pix
);

	logic               valid_s3;
	logic               valid_s4;
	logic [AMT_W-1:0]   inv_amt;
	logic [AGRAY_W-1:0] agray_s3;
	logic [WCHAN_W-1:0] wr_s3;
	logic [WCHAN_W-1:0] wg_s3;
	logic [WCHAN_W-1:0] wb_s3;
	logic [CHAN_W-1:0]  alpha_s3;
	pixel_t             pix_s4;
	logic               en_s3;
	logic               en_s4;

	function automatic logic [CHAN_W-1:0] round_clamp(
		input logic [WCHAN_W-1:0] wchan,
		input logic [AGRAY_W-1:0] agray
	);
		logic [ACC_W-1:0] acc;
		logic [8:0]       top;
		acc = {1'b0, wchan, 16'd0} + {1'b0, agray} + ROUND_HALF;
		top = acc[ACC_W-1:24];
		return top[8] ? CHAN_MAX : top[7:0];
	endfunction

	assign inv_amt  = AMOUNT_FULL - amount;
	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign in_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s3) valid_s3 <= in_valid;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			agray_s3 <= AGRAY_W'({24'd0, amount} * {1'b0, in_item.gray});
			wr_s3    <= WCHAN_W'(inv_amt * in_item.pix.red);
			wg_s3    <= WCHAN_W'(inv_amt * in_item.pix.green);
			wb_s3    <= WCHAN_W'(inv_amt * in_item.pix.blue);
			alpha_s3 <= in_item.pix.alpha;
		end
		if (en_s4) begin
			pix_s4.red   <= round_clamp(wr_s3, agray_s3);
			pix_s4.green <= round_clamp(wg_s3, agray_s3);
			pix_s4.blue  <= round_clamp(wb_s3, agray_s3);
			pix_s4.alpha <= alpha_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_pix   = pix_s4;

endmodule

>>> sv/grayscale_desaturation_blend.sv
// Throughput: one item per cycle while m_axis_tready does not stall the output;
// four register stages (luma products, luma sum, blend products, round and clamp)
// each hold one item and advance on their own.
// Reset: valid bits clear, the pipeline is empty, blend amount returns to full gray.
// ----------------------------------------------------------------------------
// grayscale_desaturation_blend
// RGBA stream desaturation: blend each color channel toward BT.601 luma.
// ----------------------------------------------------------------------------
module grayscale_desaturation_blend import gdb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,     // blend_amount, Q1.8
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // red_out, green_out, blue_out, alpha_out
);

	logic [AMT_W-1:0] amount_q;
	logic [AMT_W-1:0] amount_sat;
	logic             mid_valid;
	logic             mid_ready;
	luma_item_t       mid_item;
	pixel_t           res_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= AMOUNT_FULL;
		end else if (cfg_we) begin
			amount_q <= cfg_wdata;
		end
	end

	// saturate anything above full gray
	assign amount_sat = (amount_q > AMOUNT_FULL) ? AMOUNT_FULL : amount_q;

	gdb_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pix    (pixel_t'(s_axis_tdata)),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_item  (mid_item)
	);

	gdb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.amount    (amount_sat),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_item   (mid_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (res_pix)
	);

	assign m_axis_tdata = res_pix;

endmodule
